/* sv/blt_pkg.sv */
// blt_pkg: constants, codes and word types for the bytecode line table lookup.
// Used by blt_core, the top level bytecode_line_table_lookup and blt_checker.
// No dependencies.
`default_nettype none

package blt_pkg;

    // Address arithmetic
    localparam int unsigned CODE_UNIT_BYTES = 2;   // bytes per instruction, 1..8
    localparam int unsigned ADDR_W          = 32;  // address wrap width, 16..32
    localparam int unsigned LINE_W          = 32;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [LINE_W-1:0] t_line;

    // Table formats
    localparam logic FMT_LNOTAB = 1'b0;
    localparam logic FMT_LOCTAB = 1'b1;

    // lnotab line delta that marks a range with no line
    localparam logic [7:0] LNO_NO_LINE = 8'h80;

    // Location table entry codes
    localparam logic [3:0] LOC_CODE_ONE_LINE0  = 4'd10;
    localparam logic [3:0] LOC_CODE_ONE_LINE2  = 4'd12;
    localparam logic [3:0] LOC_CODE_NO_COLUMNS = 4'd13;
    localparam logic [3:0] LOC_CODE_LONG       = 4'd14;
    localparam logic [3:0] LOC_CODE_NONE       = 4'd15;

    // Varint decode
    localparam int unsigned  VARINT_MORE_BIT    = 6;
    localparam logic [5:0]   VARINT_SHIFT_STEP  = 6'd6;
    localparam logic [5:0]   VARINT_SHIFT_LIMIT = 6'd32;
    localparam logic [2:0]   LONG_LAST_FIELD    = 3'd4;
    localparam logic [2:0]   FIELD_HEADER       = 3'd0;
    localparam logic [2:0]   FIELD_FIRST        = 3'd1;
    localparam logic [2:0]   FIELD_SECOND       = 3'd2;

    // Configuration register indexes
    localparam int unsigned     CFG_IDX_W        = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LINE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_INDEX = 2'd2;

    typedef struct packed {
        logic               table_format;
        logic        [31:0] start_line;
        logic signed [31:0] target_index;
    } t_cfg;

    typedef struct packed {
        logic [7:0] table_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [31:0] src_line;
        logic        found;
    } t_out_word;

endpackage

`default_nettype wire

/* sv/blt_core.sv */
// blt_core: parse state of the line table and the per-byte update logic.
// One byte is consumed per i_step; the result for the last byte is combinational.
// Depends on blt_pkg.
`default_nettype none

module blt_core
    import blt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire t_in_word  i_word,
    input  wire t_cfg      i_cfg,
    output t_out_word      o_res
);

    // parse state
    t_line       r_accum,  n_accum;
    t_addr       r_start,  n_start;
    t_addr       r_end,    n_end;
    logic        r_phase,  n_phase;
    logic [7:0]  r_held,   n_held;
    logic [3:0]  r_code,   n_code;
    logic [3:0]  r_len,    n_len;
    logic [2:0]  r_field,  n_field;
    logic [31:0] r_vval,   n_vval;
    logic [5:0]  r_vshift, n_vshift;
    t_line       r_ldelta, n_ldelta;
    logic        r_decided, n_decided;
    t_line       r_ans,    n_ans;
    logic        r_found,  n_found;

    t_addr w_off;
    assign w_off = t_addr'(i_cfg.target_index) * t_addr'(CODE_UNIT_BYTES);

    always_comb begin
        logic [7:0]  b;
        logic        last;
        t_addr       pair_sum;
        logic        close;
        logic [31:0] vv;
        logic [31:0] mag;
        t_addr       close_end;

        b        = i_word.table_byte;
        last     = i_word.last_byte;
        pair_sum = r_end + t_addr'(r_held);
        close    = 1'b0;
        vv       = r_vval;
        mag      = '0;
        close_end = '0;

        n_accum   = r_accum;
        n_start   = r_start;
        n_end     = r_end;
        n_phase   = r_phase;
        n_held    = r_held;
        n_code    = r_code;
        n_len     = r_len;
        n_field   = r_field;
        n_vval    = r_vval;
        n_vshift  = r_vshift;
        n_ldelta  = r_ldelta;
        n_decided = r_decided;
        n_ans     = r_ans;
        n_found   = r_found;

        if (!r_decided) begin
            if (i_cfg.table_format == FMT_LNOTAB) begin
                // a lone trailing offset byte is dropped
                if (!(last && !r_phase)) begin
                    if (!r_phase) begin
                        n_held  = b;
                        n_phase = 1'b1;
                    end else begin
                        n_phase = 1'b0;
                        if (b == 8'd0) begin
                            n_end = pair_sum;
                        end else begin
                            n_start = r_end;
                            n_end   = pair_sum;
                            if (b != LNO_NO_LINE) begin
                                n_accum = r_accum + t_line'({{24{b[7]}}, b});
                                if (pair_sum != r_end && r_end <= w_off && w_off < pair_sum) begin
                                    n_decided = 1'b1;
                                    n_found   = 1'b1;
                                    n_ans     = i_cfg.start_line + n_accum;
                                end
                            end
                        end
                    end
                end
            end else begin
                if (r_field == FIELD_HEADER) begin
                    n_len    = {1'b0, b[2:0]} + 4'd1;
                    n_code   = b[6:3];
                    n_ldelta = (n_code inside {[LOC_CODE_ONE_LINE0:LOC_CODE_ONE_LINE2]}) ?
                               t_line'(n_code - LOC_CODE_ONE_LINE0) : '0;
                    n_vval   = '0;
                    n_vshift = '0;
                    if (n_code == LOC_CODE_NONE) begin
                        close = 1'b1;
                    end else begin
                        n_field = FIELD_FIRST;
                    end
                end else if (r_code == LOC_CODE_NO_COLUMNS || r_code == LOC_CODE_LONG) begin
                    // bits are disjoint, so accumulate by OR; high bits drop off
                    if (r_vshift < VARINT_SHIFT_LIMIT) begin
                        vv = r_vval | (32'(b[5:0]) << r_vshift);
                    end
                    if (b[VARINT_MORE_BIT]) begin
                        n_vval = vv;
                        if (r_vshift < VARINT_SHIFT_LIMIT) begin
                            n_vshift = r_vshift + VARINT_SHIFT_STEP;
                        end
                    end else begin
                        if (r_field == FIELD_FIRST) begin
                            mag      = vv >> 1;
                            n_ldelta = vv[0] ? t_line'(32'd0 - mag) : t_line'(mag);
                        end
                        n_vval   = '0;
                        n_vshift = '0;
                        if (r_code == LOC_CODE_NO_COLUMNS || r_field >= LONG_LAST_FIELD) begin
                            close = 1'b1;
                        end else begin
                            n_field = r_field + 3'd1;
                        end
                    end
                end else if (r_code >= LOC_CODE_ONE_LINE0 && r_field == FIELD_FIRST) begin
                    n_field = FIELD_SECOND;
                end else begin
                    close = 1'b1;
                end

                // table ends inside an entry: close it anyway
                if (!close && last && n_field != FIELD_HEADER) begin
                    close = 1'b1;
                end

                if (close) begin
                    close_end = r_start + t_addr'(n_len) * t_addr'(CODE_UNIT_BYTES);
                    n_accum   = r_accum + n_ldelta;
                    n_field   = FIELD_HEADER;
                    n_vval    = '0;
                    n_vshift  = '0;
                    if (r_start <= w_off && w_off < close_end) begin
                        n_decided = 1'b1;
                        n_found   = 1'b1;
                        n_ans     = i_cfg.start_line + n_accum;
                    end else if (close_end > w_off) begin
                        n_decided = 1'b1;   // passed the target
                    end
                    n_start = close_end;
                    n_end   = close_end;
                end
            end
        end

        if (i_cfg.target_index[31]) begin
            o_res.src_line = i_cfg.start_line;
            o_res.found    = 1'b1;
        end else if (n_found) begin
            o_res.src_line = n_ans;
            o_res.found    = 1'b1;
        end else begin
            o_res.src_line = '0;
            o_res.found    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_word.last_byte)) begin
            r_accum   <= '0;
            r_start   <= '0;
            r_end     <= '0;
            r_phase   <= 1'b0;
            r_held    <= '0;
            r_code    <= '0;
            r_len     <= '0;
            r_field   <= FIELD_HEADER;
            r_vval    <= '0;
            r_vshift  <= '0;
            r_ldelta  <= '0;
            r_decided <= 1'b0;
            r_ans     <= '0;
            r_found   <= 1'b0;
        end else if (i_step) begin
            r_accum   <= n_accum;
            r_start   <= n_start;
            r_end     <= n_end;
            r_phase   <= n_phase;
            r_held    <= n_held;
            r_code    <= n_code;
            r_len     <= n_len;
            r_field   <= n_field;
            r_vval    <= n_vval;
            r_vshift  <= n_vshift;
            r_ldelta  <= n_ldelta;
            r_decided <= n_decided;
            r_ans     <= n_ans;
            r_found   <= n_found;
        end
    end

endmodule

`default_nettype wire

/* sv/bytecode_line_table_lookup.sv */
// bytecode_line_table_lookup: top level, input/output registers and config registers.
// Instantiates blt_core; depends on blt_pkg.
// Checked by blt_checker (bound from its own file).
`default_nettype none

// Streams a bytecode line table one byte per word and returns the source line that
// covers instruction target_index (byte offset target_index * CODE_UNIT_BYTES).
// table_format selects lnotab pairs (0) or the varint location table (1). Exactly
// one result word comes out per table, for the word marked last_byte; a negative
// target_index returns start_line with found set, a miss returns line 0, found 0.
// After the last byte the parse state re-arms for the next table; the config
// registers are kept. Rate: one byte per clock, sustained, limited by the
// state update (entry close: an address add, line add and range compare).
// The last byte passes the input register and blt_core, and its result word
// is then held in the output register. Input is stalled only when a last
// byte waits on a full, stalled output register. No clearing pass after
// reset. Config writes are always ready; an index past target_index is
// ignored. Write config only between tables or while no byte is in flight.

module bytecode_line_table_lookup
    import blt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // table byte channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_word             i_in_word,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_word                 o_out_word,
    // config write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    logic      w_step;
    logic      w_out_load;
    t_out_word w_res;

    // output register takes a new word when empty or being drained
    assign w_out_load = !r_out_valid || !i_out_stall;
    // only a last byte needs room at the output
    assign w_step     = r_in_valid && (!r_in_word.last_byte || w_out_load);

    assign o_in_stall  = r_in_valid && !w_step;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.table_format <= FMT_LOCTAB;
            r_cfg.start_line   <= '0;
            r_cfg.target_index <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TABLE_FORMAT: r_cfg.table_format <= i_cfg_data[0];
                CFG_START_LINE:   r_cfg.start_line   <= i_cfg_data;
                CFG_TARGET_INDEX: r_cfg.target_index <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_in_word;
        end
    end

    blt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_word  (r_in_word),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= w_step && r_in_word.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load && w_step && r_in_word.last_byte) begin
            r_out_word <= w_res;
        end
    end

endmodule

`default_nettype wire

/* sv/blt_checker.sv */
// blt_checker: port-level assertions for bytecode_line_table_lookup, plus its bind.
// Depends on blt_pkg.
`default_nettype none

module blt_checker
    import blt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 o_in_stall,
    input  wire logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    input  wire t_out_word            o_out_word
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // a miss always reports line zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.found |-> o_out_word.src_line == 32'd0)
        else $error("line number nonzero without found");

    // input backs up only behind a stalled, full output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output free");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind bytecode_line_table_lookup blt_checker u_blt_checker (.*);

`default_nettype wire
